/* hw/rtl/lsfd_pkg.sv */
// Package for the laser scan frame decoder: framing constants, the
// front-to-back queue entry type and the front sequencer phase type.
// No dependencies.
package lsfd_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'hFA;
   localparam logic [7:0] HDR_BASE   = 8'hA0;

   // Byte positions inside a 42-byte packet.
   localparam logic [5:0] POS_SPEED_LO   = 6'd2;
   localparam logic [5:0] POS_SPEED_HI   = 6'd3;
   localparam logic [5:0] POS_FIRST_READ = 6'd4;
   localparam logic [5:0] POS_CHECKSUM   = 6'd40;
   localparam logic [5:0] POS_LAST       = 6'd41;
   localparam logic [5:0] PKT_LAST       = 6'd59;

   // Byte slots inside one 6-byte reading.
   localparam logic [2:0] SUB_INT_LO = 3'd0;
   localparam logic [2:0] SUB_INT_HI = 3'd1;
   localparam logic [2:0] SUB_RNG_LO = 3'd2;
   localparam logic [2:0] SUB_RNG_HI = 3'd3;
   localparam logic [2:0] SUB_LAST   = 3'd5;

   localparam logic [8:0] LAST_ANGLE     = 9'd359;
   localparam logic [8:0] ANGLES_PER_PKT = 9'd6;

   // speed / 10 == (speed * 52429) >> 19 for every 16-bit speed.
   localparam logic [16:0] RPM_RECIP = 17'd52429;
   localparam int          RPM_SHIFT = 19;
   localparam int          RPM_W     = 13;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SECOND,
      PH_FRAME
   } phase_type;

   typedef enum logic {
      EV_SPEED,
      EV_READING
   } event_kind_type;

   // word_a: speed word or range word; word_b: intensity word.
   typedef struct packed {
      event_kind_type kind;
      logic [15:0]    word_a;
      logic [15:0]    word_b;
      logic [8:0]     angle;
   } event_type;

endpackage

/* hw/rtl/lsfd_req_if.sv */
// Input channel of the scan frame decoder: one serial byte per word.
// Depends on nothing.
interface lsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/lsfd_rsp_if.sv */
// Result channel of the scan frame decoder: one range reading per word.
// Depends on nothing.
interface lsfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  angle_deg;
   logic [15:0] range_mm;
   logic [15:0] intensity;
   logic [12:0] rpm;
   logic [31:0] speed_sum;
   logic        scan_last;

   modport source (output valid, output angle_deg, output range_mm, output intensity,
                   output rpm, output speed_sum, output scan_last, input ready);
   modport sink (input valid, input angle_deg, input range_mm, input intensity,
                 input rpm, input speed_sum, input scan_last, output ready);
endinterface

/* hw/rtl/lsfd_front.sv */
// Front end of the scan frame decoder: frame sync, byte position tracking
// and classification of bytes into speed and reading events.
// Depends on lsfd_pkg and lsfd_req_if.
module lsfd_front (
   input  logic                clock,
   input  logic                reset,
   lsfd_req_if.sink            req_chan,
   input  logic                queue_full,
   output logic                push,
   output lsfd_pkg::event_type push_event
);

   lsfd_pkg::phase_type phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  pkt_ff, pkt_in;
   logic        ok_ff, ok_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] inten_ff, inten_in;
   logic [2:0]  sub_ff, sub_in;
   logic [2:0]  rd_ff, rd_in;
   logic [8:0]  base_ff, base_in;
   logic        fire;
   logic [7:0]  b;

   assign req_chan.ready = !queue_full;
   assign fire = req_chan.valid && !queue_full;
   assign b    = req_chan.rx_byte;

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            lsfd_pkg::PH_HUNT: begin
               if (b == lsfd_pkg::SYNC_BYTE) phase_in = lsfd_pkg::PH_SECOND;
            end
            lsfd_pkg::PH_SECOND: begin
               phase_in = (b == lsfd_pkg::HDR_BASE) ? lsfd_pkg::PH_FRAME : lsfd_pkg::PH_HUNT;
            end
            lsfd_pkg::PH_FRAME: begin
               if (pos_ff == lsfd_pkg::POS_LAST && pkt_ff == lsfd_pkg::PKT_LAST) begin
                  phase_in = lsfd_pkg::PH_HUNT;
               end
            end
            default: phase_in = lsfd_pkg::PH_HUNT;
         endcase
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      pkt_in   = pkt_ff;
      ok_in    = ok_ff;
      low_in   = low_ff;
      inten_in = inten_ff;
      sub_in   = sub_ff;
      rd_in    = rd_ff;
      base_in  = base_ff;
      push     = 1'b0;
      push_event.kind   = lsfd_pkg::EV_READING;
      push_event.word_a = {b, low_ff};
      push_event.word_b = inten_ff;
      push_event.angle  = base_ff - {6'd0, rd_ff};
      if (fire) begin
         case (phase_ff)
            lsfd_pkg::PH_SECOND: begin
               if (b == lsfd_pkg::HDR_BASE) begin
                  pos_in  = lsfd_pkg::POS_SPEED_LO;
                  pkt_in  = 6'd0;
                  ok_in   = 1'b1;
                  base_in = lsfd_pkg::LAST_ANGLE;
               end
            end
            lsfd_pkg::PH_FRAME: begin
               if (pos_ff == 6'd0) begin
                  ok_in = (b == lsfd_pkg::SYNC_BYTE);
               end else if (pos_ff == 6'd1) begin
                  ok_in = ok_ff && (b == lsfd_pkg::HDR_BASE + {2'b00, pkt_ff});
               end else if (pos_ff == lsfd_pkg::POS_SPEED_LO) begin
                  low_in = b;
               end else if (pos_ff == lsfd_pkg::POS_SPEED_HI) begin
                  push            = ok_ff;
                  push_event.kind = lsfd_pkg::EV_SPEED;
                  sub_in          = 3'd0;
                  rd_in           = 3'd0;
               end else if (pos_ff < lsfd_pkg::POS_CHECKSUM) begin
                  case (sub_ff)
                     lsfd_pkg::SUB_INT_LO: low_in = b;
                     lsfd_pkg::SUB_RNG_LO: low_in = b;
                     lsfd_pkg::SUB_INT_HI: inten_in = {b, low_ff};
                     lsfd_pkg::SUB_RNG_HI: push = ok_ff;
                     default: ;
                  endcase
                  if (sub_ff == lsfd_pkg::SUB_LAST) begin
                     sub_in = 3'd0;
                     rd_in  = rd_ff + 3'd1;
                  end else begin
                     sub_in = sub_ff + 3'd1;
                  end
               end
               // The checksum bytes only advance the position; the last one also steps the packet and base angle.
               if (pos_ff == lsfd_pkg::POS_LAST) begin
                  pos_in  = 6'd0;
                  pkt_in  = (pkt_ff == lsfd_pkg::PKT_LAST) ? 6'd0 : pkt_ff + 6'd1;
                  base_in = base_ff - lsfd_pkg::ANGLES_PER_PKT;
               end else begin
                  pos_in = pos_ff + 6'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lsfd_pkg::PH_HUNT;
         pos_ff   <= 6'd0;
         pkt_ff   <= 6'd0;
         ok_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         pkt_ff   <= pkt_in;
         ok_ff    <= ok_in;
      end
      low_ff   <= low_in;
      inten_ff <= inten_in;
      sub_ff   <= sub_in;
      rd_ff    <= rd_in;
      base_ff  <= base_in;
   end

endmodule

/* hw/rtl/lsfd_queue.sv */
// Short event queue between the front end and the back end.
// Depends on lsfd_pkg.
module lsfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lsfd_pkg::event_type push_event,
   input  logic                pop,
   output lsfd_pkg::event_type head,
   output logic                empty,
   output logic                full
);

   lsfd_pkg::event_type slot_ff [lsfd_pkg::QUEUE_DEPTH];
   logic [lsfd_pkg::QUEUE_AW-1:0] wr_ff, wr_in;
   logic [lsfd_pkg::QUEUE_AW-1:0] rd_ff, rd_in;
   logic [lsfd_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (lsfd_pkg::QUEUE_AW+1)'(lsfd_pkg::QUEUE_DEPTH));
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + (lsfd_pkg::QUEUE_AW)'(1) : wr_ff;
      rd_in    = pop ? rd_ff + (lsfd_pkg::QUEUE_AW)'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (lsfd_pkg::QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (lsfd_pkg::QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_event;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("event pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("event popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (lsfd_pkg::QUEUE_AW+1)'(lsfd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ff == rd_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

/* hw/rtl/lsfd_back.sv */
// Back end of the scan frame decoder: rpm and speed total upkeep and the
// result output register.
// Depends on lsfd_pkg and lsfd_rsp_if.
module lsfd_back (
   input  logic                clock,
   input  logic                reset,
   input  lsfd_pkg::event_type head,
   input  logic                empty,
   output logic                pop,
   lsfd_rsp_if.source          rsp_chan
);

   logic [lsfd_pkg::RPM_W-1:0] rpm_ff, rpm_in;
   logic [31:0] sum_ff, sum_in;
   logic [32:0] rpm_product;
   logic        valid_ff, valid_in;
   logic        load;
   logic [8:0]  angle_ff;
   logic [15:0] range_ff;
   logic [15:0] inten_ff;
   logic [12:0] out_rpm_ff;
   logic [31:0] out_sum_ff;
   logic        last_ff;

   // A speed event never waits on the output; a reading needs a free slot.
   assign load = !empty && (head.kind == lsfd_pkg::EV_READING)
                 && (!valid_ff || rsp_chan.ready);
   assign pop  = !empty && ((head.kind == lsfd_pkg::EV_SPEED) || !valid_ff || rsp_chan.ready);

   assign rpm_product = head.word_a * lsfd_pkg::RPM_RECIP;

   always_comb begin
      rpm_in = rpm_ff;
      sum_in = sum_ff;
      if (!empty && head.kind == lsfd_pkg::EV_SPEED) begin
         rpm_in = rpm_product[lsfd_pkg::RPM_SHIFT +: lsfd_pkg::RPM_W];
         sum_in = sum_ff + {16'd0, head.word_a};
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_ff   <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         rpm_ff   <= rpm_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         angle_ff   <= head.angle;
         range_ff   <= head.word_a;
         inten_ff   <= head.word_b;
         out_rpm_ff <= rpm_ff;
         out_sum_ff <= sum_ff;
         last_ff    <= (head.angle == 9'd0);
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.angle_deg = angle_ff;
   assign rsp_chan.range_mm  = range_ff;
   assign rsp_chan.intensity = inten_ff;
   assign rsp_chan.rpm       = out_rpm_ff;
   assign rsp_chan.speed_sum = out_sum_ff;
   assign rsp_chan.scan_last = last_ff;

endmodule

/* hw/rtl/lidar_scan_frame_decoder.sv */
// Top level of the laser scan frame decoder.
// Depends on lsfd_pkg, lsfd_req_if, lsfd_rsp_if, lsfd_front, lsfd_queue, lsfd_back.
//
// Usage:
//   req_chan carries the scanner's serial bytes, one byte per word.
//   rsp_chan carries one word per valid range reading: angle slot, range,
//   intensity, the rpm and speed total as of the packet's speed word, and
//   scan_last on the reading at angle 0.
//   The decoder hunts for the two-byte frame start, then walks the 60
//   packets of the frame by byte position; packets with a bad header give
//   no words, and the block hunts again after the last packet.
//   Throughput: one byte per cycle while the queue is not full. The edge
//   that accepts a reading's final range byte queues its event; the output
//   register loads it at the queue head once the output slot is free.
//   When rsp_chan stalls, reading events collect in the four-entry queue;
//   req_chan.ready drops only once that queue is full.
//   Reset (synchronous, active high) returns the decoder to hunting and
//   clears the rpm, the speed total and all queued or pending words.
module lidar_scan_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   lsfd_req_if.sink    req_chan,
   lsfd_rsp_if.source  rsp_chan
);

   logic                push;
   lsfd_pkg::event_type push_event;
   logic                pop;
   lsfd_pkg::event_type head;
   logic                empty;
   logic                full;

   lsfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (full),
      .push       (push),
      .push_event (push_event)
   );

   lsfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   lsfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* tb/lidar_scan_frame_decoder_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the laser scan frame decoder: feeds a serial byte stream of
// noise and the leading packets of a frame, predicts every reading word and checks it.
// Depends on lsfd_pkg, lsfd_req_if, lsfd_rsp_if and lidar_scan_frame_decoder.
module lidar_scan_frame_decoder_test;

   localparam int PKT_BYTES   = 42;
   localparam int PKT_FRAME   = 60;
   localparam int PKT_SENT    = 25;
   localparam int READ_BYTES  = 6;
   localparam int RPM_DIVISOR = 10;

   typedef struct {
      logic [8:0]  angle_deg;
      logic [15:0] range_mm;
      logic [15:0] intensity;
      logic [12:0] rpm;
      logic [31:0] speed_sum;
      logic        scan_last;
   } scan_reading_type;

   logic clock = 1'b0;
   logic reset;

   lsfd_req_if req_chan();
   lsfd_rsp_if rsp_chan();

   lidar_scan_frame_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   logic [7:0]       pending_bytes[$];
   scan_reading_type expected_readings[$];
   int               mismatch_count = 0;

   // Decoder state as the testbench tracks it.
   lsfd_pkg::phase_type sync_state;
   int                  pkt_byte;
   int                  pkt_index;
   logic                pkt_good;
   logic [7:0]          low_byte;
   logic [15:0]         intensity_word;
   logic [12:0]         rpm_now;
   logic [31:0]         speed_acc;

   int               send_pause;
   int               hold_left;
   int               stall;
   bit               req_steady = 1'b0;
   bit               rsp_steady = 1'b0;
   scan_reading_type want;

   // Advances the tracked decoder state by one accepted byte and queues any reading word.
   task automatic decode_rx_byte(input logic [7:0] b);
      int               sub;
      int               slot;
      int               reading_idx;
      logic [15:0]      speed;
      scan_reading_type r;
      case (sync_state)
         lsfd_pkg::PH_HUNT: begin
            if (b == lsfd_pkg::SYNC_BYTE) sync_state = lsfd_pkg::PH_SECOND;
         end
         lsfd_pkg::PH_SECOND: begin
            if (b == lsfd_pkg::HDR_BASE) begin
               sync_state = lsfd_pkg::PH_FRAME;
               pkt_byte   = 2;
               pkt_index  = 0;
               pkt_good   = 1'b1;
            end else begin
               sync_state = lsfd_pkg::PH_HUNT;
            end
         end
         lsfd_pkg::PH_FRAME: begin
            if (pkt_byte == 0) begin
               pkt_good = (b == lsfd_pkg::SYNC_BYTE);
            end else if (pkt_byte == 1) begin
               pkt_good = pkt_good && (b == 8'(lsfd_pkg::HDR_BASE + 8'(pkt_index)));
            end else if (pkt_byte == int'(lsfd_pkg::POS_SPEED_LO)) begin
               low_byte = b;
            end else if (pkt_byte == int'(lsfd_pkg::POS_SPEED_HI)) begin
               if (pkt_good) begin
                  speed     = {b, low_byte};
                  speed_acc = speed_acc + 32'(speed);
                  rpm_now   = 13'(speed / RPM_DIVISOR);
               end
            end else if (pkt_byte < int'(lsfd_pkg::POS_CHECKSUM)) begin
               sub  = (pkt_byte - int'(lsfd_pkg::POS_FIRST_READ)) % READ_BYTES;
               slot = (pkt_byte - int'(lsfd_pkg::POS_FIRST_READ)) / READ_BYTES;
               if (sub == int'(lsfd_pkg::SUB_INT_LO) || sub == int'(lsfd_pkg::SUB_RNG_LO)) begin
                  low_byte = b;
               end else if (sub == int'(lsfd_pkg::SUB_INT_HI)) begin
                  intensity_word = {b, low_byte};
               end else if (sub == int'(lsfd_pkg::SUB_RNG_HI) && pkt_good) begin
                  reading_idx = READ_BYTES * pkt_index + slot;
                  r.angle_deg = 9'(int'(lsfd_pkg::LAST_ANGLE) - reading_idx);
                  r.range_mm  = {b, low_byte};
                  r.intensity = intensity_word;
                  r.rpm       = rpm_now;
                  r.speed_sum = speed_acc;
                  r.scan_last = (reading_idx == int'(lsfd_pkg::LAST_ANGLE));
                  expected_readings.push_back(r);
               end
            end
            pkt_byte++;
            if (pkt_byte >= PKT_BYTES) begin
               pkt_byte = 0;
               pkt_index++;
               if (pkt_index >= PKT_FRAME) begin
                  pkt_index  = 0;
                  sync_state = lsfd_pkg::PH_HUNT;
               end
            end
         end
         default: sync_state = lsfd_pkg::PH_HUNT;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // Mostly random words, with the extremes and small speeds now and then.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 19));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic push_word(input logic [15:0] w);
      pending_bytes.push_back(w[7:0]);
      pending_bytes.push_back(w[15:8]);
   endtask

   // Byte driver: sends the pending bytes, pausing at random between bytes.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.rx_byte <= 8'h00;
         send_pause       <= 0;
         sync_state     = lsfd_pkg::PH_HUNT;
         pkt_byte       = 0;
         pkt_index      = 0;
         pkt_good       = 1'b0;
         low_byte       = '0;
         intensity_word = '0;
         rpm_now        = '0;
         speed_acc      = '0;
         expected_readings.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            decode_rx_byte(req_chan.rx_byte);
         if (!req_chan.valid || req_chan.ready) begin
            if (send_pause > 0) begin
               req_chan.valid <= 1'b0;
               send_pause     <= send_pause - 1;
            end else if (pending_bytes.size() > 0) begin
               req_chan.valid   <= 1'b1;
               req_chan.rx_byte <= pending_bytes.pop_front();
               if ($urandom_range(0, 99) == 0) req_steady = !req_steady;
               send_pause <= req_steady ? 0 : $urandom_range(0, 12);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Reading monitor: stalls at random after each word and checks it against the oldest
   // expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: expected no reading word, got angle %0d range %0d", $time,
                        rsp_chan.angle_deg, rsp_chan.range_mm);
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               check_field("angle_deg", 32'(want.angle_deg), 32'(rsp_chan.angle_deg));
               check_field("range_mm", 32'(want.range_mm), 32'(rsp_chan.range_mm));
               check_field("intensity", 32'(want.intensity), 32'(rsp_chan.intensity));
               check_field("rpm", 32'(want.rpm), 32'(rsp_chan.rpm));
               check_field("speed_sum", want.speed_sum, rsp_chan.speed_sum);
               check_field("scan_last", 32'(want.scan_last), 32'(rsp_chan.scan_last));
            end
            if ($urandom_range(0, 99) == 0) rsp_steady = !rsp_steady;
            stall = rsp_steady ? 0 : $urandom_range(0, 12);
            hold_left      <= stall;
            rsp_chan.ready <= (stall == 0);
         end else if (!rsp_chan.ready) begin
            if (hold_left <= 1) rsp_chan.ready <= 1'b1;
            if (hold_left > 0) hold_left <= hold_left - 1;
         end
      end
   end

   initial begin : stimulus
      int         pkt;
      int         k;
      int         n;
      logic [7:0] b;
      reset = 1'b1;

      // Start-byte hunting: a stray header byte, a bad second byte, a second start byte
      // that is swallowed as the bad second byte, and the byte extremes.
      pending_bytes = '{lsfd_pkg::HDR_BASE, 8'h00, 8'hFF, lsfd_pkg::SYNC_BYTE, 8'h00,
                        lsfd_pkg::SYNC_BYTE, lsfd_pkg::SYNC_BYTE, lsfd_pkg::HDR_BASE, 8'h17,
                        lsfd_pkg::SYNC_BYTE, 8'hFF, 8'h42};

      // Noise never holds a header byte, so it cannot open a frame by itself, and it
      // never ends on a start byte, so the frame that follows stays aligned.
      n = $urandom_range(1, 40);
      for (k = 0; k < n; k++) begin
         b = ($urandom_range(0, 3) == 0) ? lsfd_pkg::SYNC_BYTE : 8'($urandom());
         if (b == lsfd_pkg::HDR_BASE || (k == n - 1 && b == lsfd_pkg::SYNC_BYTE)) b = 8'h00;
         pending_bytes.push_back(b);
      end

      // Only the leading packets of the frame are sent; the decoder stays inside it.
      pending_bytes.push_back(lsfd_pkg::SYNC_BYTE);
      pending_bytes.push_back(lsfd_pkg::HDR_BASE);
      for (pkt = 0; pkt < PKT_SENT; pkt++) begin
         if (pkt > 0) begin
            if ($urandom_range(0, 7) == 0) begin
               if ($urandom_range(0, 1) == 0) begin
                  b = 8'($urandom());
                  if (b == lsfd_pkg::SYNC_BYTE) b = 8'h00;
                  pending_bytes.push_back(b);
                  pending_bytes.push_back(8'(lsfd_pkg::HDR_BASE + 8'(pkt)));
               end else begin
                  pending_bytes.push_back(lsfd_pkg::SYNC_BYTE);
                  pending_bytes.push_back(8'(lsfd_pkg::HDR_BASE + 8'(pkt)
                                             + 8'($urandom_range(1, 200))));
               end
            end else begin
               pending_bytes.push_back(lsfd_pkg::SYNC_BYTE);
               pending_bytes.push_back(8'(lsfd_pkg::HDR_BASE + 8'(pkt)));
            end
         end
         push_word(pick_word());
         for (k = 0; k < READ_BYTES; k++) begin
            push_word(pick_word());
            push_word(pick_word());
            pending_bytes.push_back(8'($urandom()));
            pending_bytes.push_back(8'($urandom()));
         end
         pending_bytes.push_back(8'($urandom()));
         pending_bytes.push_back(8'($urandom()));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_chan.valid !== 1'b0) @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("lidar_scan_frame_decoder: match");
      end else begin
         $display("lidar_scan_frame_decoder: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("lidar_scan_frame_decoder: mismatch");
      $finish;
   end

endmodule

/* lidar_scan_frame_decoder.f */
hw/rtl/lsfd_pkg.sv
hw/rtl/lsfd_req_if.sv
hw/rtl/lsfd_rsp_if.sv
hw/rtl/lsfd_front.sv
hw/rtl/lsfd_queue.sv
hw/rtl/lsfd_back.sv
hw/rtl/lidar_scan_frame_decoder.sv
tb/lidar_scan_frame_decoder_test.sv
